// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the LED scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CLPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define CLPS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ----- rtl/clps_pkg.sv -----
// Package of types, codes and pin patterns for the charlieplexed LED scanner.
package clps_pkg;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_PLAY   = 3'd1,
    REQ_PAUSE  = 3'd2,
    REQ_SET    = 3'd3,
    REQ_KEY    = 3'd4,
    REQ_INIT   = 3'd5,
    REQ_UNINIT = 3'd6
  } req_code_t;

  // Display modes
  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_UPPER  = 3'd1,
    MODE_LOWER  = 3'd2,
    MODE_ALL    = 3'd3,
    MODE_BLINK  = 3'd4,
    MODE_CIRCLE = 3'd5
  } mode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLINK_ON     = 2'd0;
  localparam logic [1:0] CFG_BLINK_PERIOD = 2'd1;
  localparam logic [1:0] CFG_SEGMENT      = 2'd2;

  localparam logic [15:0] BLINK_ON_RESET     = 16'd500;
  localparam logic [15:0] BLINK_PERIOD_RESET = 16'd1000;
  localparam logic [13:0] SEGMENT_RESET      = 14'd400;

  // Pin drive codes
  localparam logic [1:0] PIN_LOW   = 2'd0;
  localparam logic [1:0] PIN_HIGH  = 2'd1;
  localparam logic [1:0] PIN_FLOAT = 2'd2;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] c;
  } pins_t;

  // LED patterns on the three pins
  localparam pins_t PAT_UL    = '{a: PIN_FLOAT, b: PIN_HIGH,  c: PIN_LOW};
  localparam pins_t PAT_UR    = '{a: PIN_FLOAT, b: PIN_LOW,   c: PIN_HIGH};
  localparam pins_t PAT_LL    = '{a: PIN_LOW,   b: PIN_FLOAT, c: PIN_HIGH};
  localparam pins_t PAT_LR    = '{a: PIN_HIGH,  b: PIN_FLOAT, c: PIN_LOW};
  localparam pins_t PAT_LOW   = '{a: PIN_LOW,   b: PIN_LOW,   c: PIN_LOW};
  localparam pins_t PAT_FLOAT = '{a: PIN_FLOAT, b: PIN_FLOAT, c: PIN_FLOAT};

  // Input item
  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] mode_select;
  } clps_req_t;

  // Result item
  typedef struct packed {
    logic [1:0] pin_a;
    logic [1:0] pin_b;
    logic [1:0] pin_c;
    logic       power_pin;
    logic       updated;
    logic       lit_enabled;
  } clps_res_t;

  // Timing registers as seen by the engine
  typedef struct packed {
    logic [15:0] blink_on_ticks;
    logic [15:0] blink_period_ticks;
    logic [13:0] circle_segment_ticks;
  } clps_cfg_t;

  // Pattern for one step of the four-phase cycle
  function automatic pins_t four_phase_pat(input logic [1:0] ph);
    pins_t p;
    unique case (ph)
      2'd0: p = PAT_UL;
      2'd1: p = PAT_UR;
      2'd2: p = PAT_LL;
      default: p = PAT_LR;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/clps_engine.sv -----
// Scanner state and the per-request update of mode, counters and pins.
module clps_engine (
  input  logic                clk,
  input  logic                rst,
  input  clps_pkg::clps_cfg_t cfg,
  input  logic                take,
  input  clps_pkg::clps_req_t req,
  output clps_pkg::clps_res_t res
);
  import clps_pkg::*;

  logic        enabled, enabled_next;
  logic        ticking, ticking_next;
  mode_t       mode, mode_next;
  logic [1:0]  phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic        power_level, power_level_next;
  pins_t       pins, pins_next;
  logic        drove;

  logic [16:0] seg1, seg2, seg3, seg4, seg5;
  logic [16:0] cnt_wide, cnt_inc;

  // Segment boundaries of the circle pattern
  assign seg1     = {3'b000, cfg.circle_segment_ticks};
  assign seg2     = {2'b00, cfg.circle_segment_ticks, 1'b0};
  assign seg4     = {1'b0, cfg.circle_segment_ticks, 2'b00};
  assign seg3     = seg2 + seg1;
  assign seg5     = seg4 + seg1;
  assign cnt_wide = {1'b0, tick_count};
  assign cnt_inc  = cnt_wide + 17'd1;

  // Work out the next state for the request on hand
  always_comb begin
    enabled_next     = enabled;
    ticking_next     = ticking;
    mode_next        = mode;
    phase_next       = phase;
    tick_count_next  = tick_count;
    power_level_next = power_level;
    pins_next        = pins;
    drove            = 1'b0;
    if (take) begin
      unique case (req_code_t'(req.req_type))
        REQ_TICK: begin
          if (enabled && ticking) begin
            drove = 1'b1;
            unique case (mode)
              MODE_OFF: pins_next = PAT_LOW;
              MODE_UPPER, MODE_LOWER: begin
                if (phase == 2'd0) begin
                  phase_next = 2'd1;
                  pins_next  = (mode == MODE_UPPER) ? PAT_UL : PAT_LL;
                end else begin
                  phase_next = 2'd0;
                  pins_next  = (mode == MODE_UPPER) ? PAT_UR : PAT_LR;
                end
              end
              MODE_ALL: begin
                pins_next  = four_phase_pat(phase);
                phase_next = phase + 2'd1;
              end
              MODE_BLINK: begin
                if (tick_count < cfg.blink_on_ticks) begin
                  pins_next  = four_phase_pat(phase);
                  phase_next = phase + 2'd1;
                end else begin
                  pins_next = PAT_LOW;
                end
                if (cnt_inc >= {1'b0, cfg.blink_period_ticks}) begin
                  tick_count_next = '0;
                end else begin
                  tick_count_next = cnt_inc[15:0];
                end
              end
              MODE_CIRCLE: begin
                tick_count_next = tick_count + 16'd1;
                priority if (cnt_wide < seg1) begin
                  pins_next  = four_phase_pat(phase);
                  phase_next = phase + 2'd1;
                end else if (cnt_wide < seg2) begin
                  pins_next = PAT_LOW;
                end else if (cnt_wide < seg3) begin
                  phase_next = (phase == 2'd0) ? 2'd1 : 2'd0;
                  pins_next  = (phase == 2'd0) ? PAT_LL : PAT_LR;
                end else if (cnt_wide < seg4) begin
                  pins_next  = four_phase_pat(phase);
                  phase_next = phase + 2'd1;
                end else if (cnt_wide < seg5) begin
                  phase_next = (phase == 2'd0) ? 2'd1 : 2'd0;
                  pins_next  = (phase == 2'd0) ? PAT_UL : PAT_UR;
                end else begin
                  // wrap the pattern: restart the count, leave the pins
                  tick_count_next = 16'd1;
                  drove           = 1'b0;
                end
              end
              default: drove = 1'b0;
            endcase
          end
        end
        REQ_PLAY: begin
          tick_count_next = '0;
          phase_next      = '0;
          mode_next       = MODE_CIRCLE;
        end
        REQ_PAUSE: mode_next = MODE_ALL;
        REQ_SET: begin
          if (req.mode_select <= 3'(MODE_CIRCLE)) begin
            mode_next = mode_t'(req.mode_select);
          end
        end
        REQ_KEY: begin
          enabled_next = !enabled;
          if (enabled) begin
            pins_next        = PAT_LOW;
            power_level_next = 1'b0;
            drove            = 1'b1;
          end else begin
            tick_count_next  = '0;
            phase_next       = '0;
            power_level_next = 1'b1;
          end
        end
        REQ_INIT: begin
          enabled_next = 1'b1;
          ticking_next = 1'b1;
          mode_next    = MODE_ALL;
        end
        REQ_UNINIT: ticking_next = 1'b0;
        default: drove = 1'b0;
      endcase
    end
  end

  // Hold the state between requests
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      ticking     <= 1'b0;
      mode        <= MODE_OFF;
      phase       <= '0;
      tick_count  <= '0;
      power_level <= 1'b1;
      pins        <= PAT_FLOAT;
    end else begin
      enabled     <= enabled_next;
      ticking     <= ticking_next;
      mode        <= mode_next;
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      power_level <= power_level_next;
      pins        <= pins_next;
    end
  end

  // Result of this request
  always_comb begin
    res.pin_a       = pins_next.a;
    res.pin_b       = pins_next.b;
    res.pin_c       = pins_next.c;
    res.power_pin   = power_level_next;
    res.updated     = drove;
    res.lit_enabled = enabled_next;
  end

endmodule

// ----- rtl/clps_out_queue.sv -----
// Two-entry result register that keeps input transfers going under output stalls.
module clps_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  clps_pkg::clps_res_t push_data,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output clps_pkg::clps_res_t out_data
);
  import clps_pkg::*;

  clps_res_t  slot0, slot1;
  logic [1:0] count, count_next;
  logic       pop;
  logic       wr_pos;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign out_data  = slot0;
  assign wr_pos    = (count == 2'd2) || ((count == 2'd1) && !pop);

  // Track occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Advance the tail entry and write the new result behind what remains
  always_ff @(posedge clk) begin
    if (pop && (count == 2'd2)) begin
      slot0 <= slot1;
    end
    if (push) begin
      if (wr_pos) begin
        slot1 <= push_data;
      end else begin
        slot0 <= push_data;
      end
    end
  end

endmodule

// ----- rtl/charlieplex_led_pattern_scanner.sv -----
// Each result is registered in the output queue on its request transfer.
// Throughput: one request per cycle; requests keep flowing while one result
// waits on the output, and in_ready drops while two results wait.
// A configuration transfer applies to requests accepted in later cycles.
// Reset (rst, synchronous) clears the scanner to disabled, off mode, pins
// floating, power high, and loads timing registers with 500, 1000 and 400.
`include "assert_macros.svh"

module charlieplex_led_pattern_scanner (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  clps_pkg::clps_req_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clps_pkg::clps_res_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import clps_pkg::*;

  clps_cfg_t cfg;
  clps_res_t res;
  logic      take;
  logic      key_off_ok;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  // Load timing registers on a configuration transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_on_ticks       <= BLINK_ON_RESET;
      cfg.blink_period_ticks   <= BLINK_PERIOD_RESET;
      cfg.circle_segment_ticks <= SEGMENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLINK_ON:     cfg.blink_on_ticks       <= cfg_data;
        CFG_BLINK_PERIOD: cfg.blink_period_ticks   <= cfg_data;
        CFG_SEGMENT:      cfg.circle_segment_ticks <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  clps_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .req  (in_data),
    .res  (res)
  );

  clps_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (res),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A key-off result shows all pins low and the supply off
  assign key_off_ok = (out_data.pin_a == PIN_LOW) && (out_data.pin_b == PIN_LOW) &&
                      (out_data.pin_c == PIN_LOW) && !out_data.power_pin;

  `CLPS_ASSERT_NEXT(a_result_follows, take, out_valid, "request transfer gave no result")
  `CLPS_ASSERT(a_full_has_result, !in_ready |-> out_valid, "queue full but no result shown")
  `CLPS_ASSERT(a_key_off_pins, out_valid && out_data.updated && !out_data.lit_enabled |-> key_off_ok, "key off did not drive pins low")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the charlieplexed LED scanner: directed and random requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Codes outside the package's lists
  localparam logic [2:0] REQ_NONE   = 3'd7;
  localparam logic [2:0] SEL_SPARE6 = 3'd6;
  localparam logic [2:0] SEL_SPARE7 = 3'd7;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  clps_req_t   in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  clps_res_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // Idle rates in percent for the request and result sides
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  int unsigned reqs_sent    = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;

  clps_res_t pending_res[$];
  clps_res_t want;

  // Predictor state and timing registers
  logic        lit_on;
  logic        scan_run;
  mode_t       cur_mode;
  logic [1:0]  scan_phase;
  logic [15:0] scan_count;
  logic        supply;
  pins_t       held_pins;
  logic [15:0] on_ticks;
  logic [15:0] period_ticks;
  logic [13:0] seg_ticks;

  charlieplex_led_pattern_scanner DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bring the predictor to its post-reset state
  task automatic scanner_reset();
    lit_on       = 1'b0;
    scan_run     = 1'b0;
    cur_mode     = MODE_OFF;
    scan_phase   = 2'd0;
    scan_count   = 16'd0;
    supply       = 1'b1;
    held_pins    = PAT_FLOAT;
    on_ticks     = 16'd500;
    period_ticks = 16'd1000;
    seg_ticks    = 14'd400;
  endtask

  // One step of the four-LED rotation
  function automatic pins_t quad_step();
    pins_t p;
    case (scan_phase)
      2'd0:    p = PAT_UL;
      2'd1:    p = PAT_UR;
      2'd2:    p = PAT_LL;
      default: p = PAT_LR;
    endcase
    scan_phase = scan_phase + 2'd1;
    return p;
  endfunction

  // Alternate left and right within one pair
  function automatic pins_t pair_step(input bit upper);
    pins_t p;
    if (scan_phase == 2'd0) begin
      scan_phase = 2'd1;
      p = upper ? PAT_UL : PAT_LL;
    end else begin
      scan_phase = 2'd0;
      p = upper ? PAT_UR : PAT_LR;
    end
    return p;
  endfunction

  // Advance the scan by one tick; returns whether the pins were driven
  function automatic bit scan_tick();
    int unsigned s;
    int unsigned c;
    bit drove;
    s = seg_ticks;
    c = scan_count;
    drove = 1'b1;
    if (!lit_on || !scan_run) return 1'b0;
    case (cur_mode)
      MODE_OFF:   held_pins = PAT_LOW;
      MODE_UPPER: held_pins = pair_step(1'b1);
      MODE_LOWER: held_pins = pair_step(1'b0);
      MODE_ALL:   held_pins = quad_step();
      MODE_BLINK: begin
        if (c < on_ticks) held_pins = quad_step();
        else held_pins = PAT_LOW;
        c = c + 1;
        if (c >= period_ticks) c = 0;
        scan_count = c[15:0];
      end
      MODE_CIRCLE: begin
        if (c < s) held_pins = quad_step();
        else if (c < 2 * s) held_pins = PAT_LOW;
        else if (c < 3 * s) held_pins = pair_step(1'b0);
        else if (c < 4 * s) held_pins = quad_step();
        else if (c < 5 * s) held_pins = pair_step(1'b1);
        else begin
          c = 0;
          drove = 1'b0;
        end
        scan_count = c[15:0] + 16'd1;
      end
      default: drove = 1'b0;
    endcase
    return drove;
  endfunction

  // Work out the result of one request and update the predictor
  function automatic clps_res_t predict_result(input clps_req_t r);
    clps_res_t res;
    bit drove;
    drove = 1'b0;
    case (r.req_type)
      REQ_TICK: drove = scan_tick();
      REQ_PLAY: begin
        scan_count = 16'd0;
        scan_phase = 2'd0;
        cur_mode   = MODE_CIRCLE;
      end
      REQ_PAUSE: cur_mode = MODE_ALL;
      REQ_SET: if (r.mode_select <= MODE_CIRCLE) cur_mode = mode_t'(r.mode_select);
      REQ_KEY: begin
        lit_on = !lit_on;
        if (!lit_on) begin
          held_pins = PAT_LOW;
          supply    = 1'b0;
          drove     = 1'b1;
        end else begin
          scan_count = 16'd0;
          scan_phase = 2'd0;
          supply     = 1'b1;
        end
      end
      REQ_INIT: begin
        lit_on   = 1'b1;
        scan_run = 1'b1;
        cur_mode = MODE_ALL;
      end
      REQ_UNINIT: scan_run = 1'b0;
      default: ;
    endcase
    res.pin_a       = held_pins.a;
    res.pin_b       = held_pins.b;
    res.pin_c       = held_pins.c;
    res.power_pin   = supply;
    res.updated     = drove;
    res.lit_enabled = lit_on;
    return res;
  endfunction

  // Offer one request, hold it until the transfer, then queue its result
  task automatic send_req(input logic [2:0] rt, input logic [2:0] sel);
    int unsigned gap;
    clps_req_t r;
    gap = 0;
    r.req_type    = rt;
    r.mode_select = sel;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    pending_res.push_back(predict_result(r));
    reqs_sent++;
  endtask

  // Drop the request valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Load all three timing registers once the scanner is idle
  task automatic set_timing(input logic [15:0] on_v, input logic [15:0] per_v,
                            input logic [15:0] seg_v);
    logic [15:0] vals [3];
    logic [1:0]  idxs [3];
    vals = '{on_v, per_v, seg_v};
    idxs = '{CFG_BLINK_ON, CFG_BLINK_PERIOD, CFG_SEGMENT};
    drain_results();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idxs[i])
        CFG_BLINK_ON:     on_ticks = vals[i];
        CFG_BLINK_PERIOD: period_ticks = vals[i];
        CFG_SEGMENT:      seg_ticks = vals[i][13:0];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // Random requests weighted towards ticks, opened by an init
  task automatic run_random(input int unsigned n);
    int unsigned pick;
    logic [2:0] rt;
    send_req(REQ_INIT, 3'($urandom_range(7)));
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) rt = REQ_TICK;
      else if (pick < 76) rt = REQ_PLAY;
      else if (pick < 79) rt = REQ_PAUSE;
      else if (pick < 87) rt = REQ_SET;
      else if (pick < 91) rt = REQ_KEY;
      else if (pick < 96) rt = REQ_INIT;
      else if (pick < 99) rt = REQ_UNINIT;
      else rt = REQ_NONE;
      send_req(rt, 3'($urandom_range(7)));
      // hold off now and then until all results are in
      if ($urandom_range(149) == 0) drain_results();
    end
  endtask

  task automatic test_directed();
    tx_idle_pct = 18;
    rx_idle_pct = 60;
    send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_SET, SEL_SPARE7);
    send_req(REQ_NONE, SEL_SPARE7);
    send_req(REQ_KEY, MODE_OFF);
    send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_INIT, MODE_OFF);
    repeat (4) send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_SET, MODE_OFF);
    send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_SET, MODE_UPPER);
    repeat (2) send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_SET, MODE_LOWER);
    send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_SET, SEL_SPARE6);
    send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_UNINIT, MODE_OFF);
    send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_INIT, MODE_OFF);
    send_req(REQ_SET, MODE_BLINK);
    send_req(REQ_TICK, MODE_OFF);
    send_req(REQ_KEY, MODE_OFF);
    send_req(REQ_KEY, MODE_OFF);
    send_req(REQ_PAUSE, MODE_OFF);
    send_req(REQ_PLAY, MODE_CIRCLE);
    send_req(REQ_TICK, MODE_OFF);
  endtask

  task automatic test_small_timing();
    set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 10)),
               16'($urandom_range(1, 6)));
    run_random(300);
  endtask

  task automatic test_zero_timing();
    tx_idle_pct = 60;
    rx_idle_pct = 18;
    set_timing(16'd0, 16'd0, 16'd0);
    run_random(150);
  endtask

  task automatic test_full_scale_timing();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(150);
  endtask

  task automatic test_mixed_timing();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (3) begin
      set_timing(16'($urandom_range(1, 40)), 16'($urandom_range(1, 60)),
                 16'($urandom_range(1, 12)));
      run_random(80);
    end
  endtask

  // Longest segment: the circle pattern stays in its first segment
  task automatic test_long_segment();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_timing(16'd3, 16'd7, 16'h3FFF);
    send_req(REQ_INIT, MODE_OFF);
    send_req(REQ_PLAY, MODE_OFF);
    repeat (40) send_req(REQ_TICK, MODE_OFF);
  endtask

  function automatic void check_field(input string name, input logic [1:0] want_v,
                                      input logic [1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result, expected none got %p", $time, out_data);
        errors++;
      end else begin
        want = pending_res.pop_front();
        check_field("pin_a", want.pin_a, out_data.pin_a);
        check_field("pin_b", want.pin_b, out_data.pin_b);
        check_field("pin_c", want.pin_c, out_data.pin_c);
        check_field("power_pin", {1'b0, want.power_pin}, {1'b0, out_data.power_pin});
        check_field("updated", {1'b0, want.updated}, {1'b0, out_data.updated});
        check_field("lit_enabled", {1'b0, want.lit_enabled},
                    {1'b0, out_data.lit_enabled});
      end
    end
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_res.size());
      $display("charlieplex_led_pattern_scanner: mismatch");
      $finish;
    end
  end

  initial begin
    scanner_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_small_timing();
    test_zero_timing();
    test_full_scale_timing();
    test_mixed_timing();
    test_long_segment();
    drain_results();
    repeat (10) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d register writes", reqs_sent,
             results_seen, reg_writes);
    $display("covered all modes and requests, zero, small, full-scale and long timing");
    if (errors == 0) begin
      $display("charlieplex_led_pattern_scanner: match");
    end else begin
      $display("charlieplex_led_pattern_scanner: mismatch");
    end
    $finish;
  end

endmodule
